// ===== rtl/core/b64e_pkg.sv =====
// Shared types, codes and the encoding alphabet for the base64 stream encoder.
package b64e_pkg;

   localparam logic FUNC_DATA = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [7:0] TERM_CHAR = 8'h00;

   localparam int JOBQ_DEPTH = 2;

   // Permuted alphabet, entry 0 is the first character of the string.
   localparam logic [0:63][7:0] ALPHABET =
      "zy0xw1vu2ts3rq4po5nm6lk7ji8hg9fedcba,.ZYXWVUTSRQPONMLKJIHGFEDCBA";

   // One job: up to four characters, emitted chars[0] .. chars[last_idx].
   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
   } job_type;

   function automatic logic [7:0] b64e_sym(input logic [5:0] idx);
      return ALPHABET[idx];
   endfunction

endpackage

// ===== rtl/core/base64_stream_encoder_top.sv =====
// Top level of the base64 stream encoder with a permuted alphabet.
// Base64 stream encoder. Each input beat is either a data byte (req_func = 0)
// or an end-of-message flush (req_func = 1). Data bytes are packed into 6-bit
// groups as in standard base64 and mapped through a fixed, permuted
// 64-character alphabet; a byte yields one character, or two when it closes a
// three-byte group. An end beat flushes a partial group with one or two '='
// pads, then emits a zero terminator and restarts at the group start.
// rsp_last_in_run marks the final character produced by each input beat.
// Both sides are queues: push a beat while full is low, take a character
// beat while empty is low by raising pop. The front end decodes a beat in
// the cycle it is pushed and stores a job of up to four characters in a
// short queue; the back end drains jobs into the output register one character
// per cycle while that register is empty or popped. A beat's first character
// passes the job queue, the current-job register and the output register in
// turn. Input beats are taken one per cycle while the job queue has room; the
// serializer sets sustained throughput, so a steady data stream yields four
// characters per three bytes, and an end beat yields one to four characters.
module base64_stream_encoder_top
   import b64e_pkg::*;
#(
   parameter int JobqDepth = JOBQ_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   // input beats
   input  logic       push,
   output logic       full,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   // result beats
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_in_run
);

   logic    accept;
   job_type front_job;
   job_type q_job;
   logic    q_valid;
   logic    q_take;

   // a beat is taken only when the job queue has a free slot
   assign accept = push && !full;

   b64e_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .data_byte (req_data_byte),
      .job       (front_job)
   );

   b64e_jobq #(
      .DEPTH (JobqDepth)
   ) u_jobq (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_job   (front_job),
      .full     (full),
      .rd_en    (q_take),
      .rd_job   (q_job),
      .rd_valid (q_valid)
   );

   // back end pulls a job when its current one is finishing or it is idle
   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (q_valid),
      .job         (q_job),
      .job_take    (q_take),
      .empty       (empty),
      .pop         (pop),
      .out_char    (rsp_out_char),
      .last_in_run (rsp_last_in_run)
   );

endmodule

// ===== rtl/core/b64e_front.sv =====
// Front end: takes input beats, tracks group phase, builds character jobs.
module b64e_front
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       func,
   input  logic [7:0] data_byte,
   output job_type    job
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] prev_low_ff, prev_low_in;

   always_comb begin
      job.chars    = '0;
      job.last_idx = 2'd0;
      phase_in     = phase_ff;
      prev_low_in  = prev_low_ff;
      if (func == FUNC_DATA) begin
         prev_low_in = data_byte[3:0];
         unique case (phase_ff)
            PHASE_1: begin
               job.chars[0] = b64e_sym({prev_low_ff[1:0], data_byte[7:4]});
               phase_in     = PHASE_2;
            end
            PHASE_2: begin
               job.chars[0] = b64e_sym({prev_low_ff, data_byte[7:6]});
               job.chars[1] = b64e_sym(data_byte[5:0]);
               job.last_idx = 2'd1;
               phase_in     = PHASE_0;
            end
            default: begin
               job.chars[0] = b64e_sym(data_byte[7:2]);
               phase_in     = PHASE_1;
            end
         endcase
      end else begin
         phase_in    = PHASE_0;
         prev_low_in = 4'd0;
         unique case (phase_ff)
            PHASE_1: begin
               job.chars[0] = b64e_sym({prev_low_ff[1:0], 4'd0});
               job.chars[1] = PAD_CHAR;
               job.chars[2] = PAD_CHAR;
               job.chars[3] = TERM_CHAR;
               job.last_idx = 2'd3;
            end
            PHASE_2: begin
               job.chars[0] = b64e_sym({prev_low_ff, 2'd0});
               job.chars[1] = PAD_CHAR;
               job.chars[2] = TERM_CHAR;
               job.last_idx = 2'd2;
            end
            default: begin
               job.chars[0] = TERM_CHAR;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_0;
         prev_low_ff <= 4'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         prev_low_ff <= prev_low_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && func == FUNC_END) |=> (phase_ff == PHASE_0 && prev_low_ff == 4'd0))
      else $error("phase not cleared after end beat");

endmodule

// ===== rtl/core/b64e_jobq.sv =====
// Short job queue between front and back ends.
module b64e_jobq
   import b64e_pkg::*;
#(
   parameter int DEPTH = JOBQ_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_job,
   output logic    full,
   input  logic    rd_en,
   output job_type rd_job,
   output logic    rd_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= ptr_next(wr_ptr_ff);
         if (rd_en) rd_ptr_ff <= ptr_next(rd_ptr_ff);
         if (wr_en && !rd_en)      count_ff <= count_ff + 1'b1;
         else if (rd_en && !wr_en) count_ff <= count_ff - 1'b1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("job queue overfilled");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("job queue count did not advance on write");

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end: serializes jobs into one character beat per cycle while the output register is empty or popped.
module b64e_back
   import b64e_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_take,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] out_char,
   output logic       last_in_run
);

   job_type    cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic       out_valid_ff;
   logic [7:0] out_char_ff;
   logic       out_last_ff;

   logic out_free, emit, cur_done;

   assign out_free = !out_valid_ff || pop;
   assign emit     = cur_valid_ff && out_free;
   assign cur_done = emit && (idx_ff == cur_ff.last_idx);
   assign job_take = job_valid && (!cur_valid_ff || cur_done);

   assign empty       = !out_valid_ff;
   assign out_char    = out_char_ff;
   assign last_in_run = out_last_ff;

   always_ff @(posedge clock) begin
      if (job_take) cur_ff <= job;
      if (emit) begin
         out_char_ff <= cur_ff.chars[idx_ff];
         out_last_ff <= (idx_ff == cur_ff.last_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job_take) begin
            cur_valid_ff <= 1'b1;
            idx_ff       <= 2'd0;
         end else if (cur_done) begin
            cur_valid_ff <= 1'b0;
         end else if (emit) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (emit)     out_valid_ff <= 1'b1;
         else if (pop) out_valid_ff <= 1'b0;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= cur_ff.last_idx)
      else $error("serializer index past end of job");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the base64 stream encoder with its permuted alphabet.
module tb_top
   import b64e_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // One input beat as the driver presents it.
   typedef struct {
      logic       func;
      logic [7:0] data;
   } in_beat_type;

   // One character beat as the encoder should deliver it.
   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_beat_type;

   // Own copy of the 64-entry symbol table; entry 0 is the leftmost character.
   localparam logic [0:63][7:0] ENC_SYMBOLS =
      "zy0xw1vu2ts3rq4po5nm6lk7ji8hg9fedcba,.ZYXWVUTSRQPONMLKJIHGFEDCBA";

   localparam int RANDOM_BEATS  = 160;
   localparam int DRAIN_CYCLES  = 20;
   localparam int MAX_GAP       = 17;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic       req_func = FUNC_DATA;
   logic [7:0] req_data_byte = 8'h00;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_in_run;

   in_beat_type   pending_beats[$];
   char_beat_type expected_chars[$];

   // Encoder state mirror: position in the 3-byte group and the carried nibble.
   logic [1:0] grp_phase = PHASE_0;
   logic [3:0] carry_bits = 4'h0;

   // Handshake bookkeeping; each counter has exactly one writer.
   int beats_sent  = 0;
   int beats_taken = 0;
   int chars_taken = 0;
   int chars_seen  = 0;
   int push_hold   = 0;
   int pop_hold    = 0;
   int mismatches  = 0;
   bit req_calm    = 1'b0;
   bit rsp_calm    = 1'b1;

   base64_stream_encoder_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_func        (req_func),
      .req_data_byte   (req_data_byte),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_in_run (rsp_last_in_run)
   );

   always #4 clock = ~clock;

   // Per-beat idle draw. Now and then a side flips between a calm stretch
   // (no idling at all) and a bursty one (idle gaps drawn anew per beat, bounded by MAX_GAP).
   function automatic int draw_gap(inout bit calm);
      if ($urandom_range(0, 15) == 0) calm = !calm;
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Appends the characters one input beat must produce, in order, with the
   // run marker on the final one, and advances the mirrored group state.
   task automatic encode_beat(input logic func, input logic [7:0] b);
      logic [7:0] run[$];
      char_beat_type cb;
      if (func == FUNC_DATA) begin
         case (grp_phase)
            PHASE_1: begin
               run.push_back(ENC_SYMBOLS[{carry_bits[1:0], b[7:4]}]);
               grp_phase = PHASE_2;
            end
            PHASE_2: begin
               // closing byte of a group yields two characters
               run.push_back(ENC_SYMBOLS[{carry_bits, b[7:6]}]);
               run.push_back(ENC_SYMBOLS[b[5:0]]);
               grp_phase = PHASE_0;
            end
            default: begin
               run.push_back(ENC_SYMBOLS[b[7:2]]);
               grp_phase = PHASE_1;
            end
         endcase
         carry_bits = b[3:0];
      end else begin
         // flush: leftover bits zero-extended, then pads, then terminator
         case (grp_phase)
            PHASE_1: begin
               run.push_back(ENC_SYMBOLS[{carry_bits[1:0], 4'h0}]);
               run.push_back(PAD_CHAR);
               run.push_back(PAD_CHAR);
            end
            PHASE_2: begin
               run.push_back(ENC_SYMBOLS[{carry_bits, 2'b00}]);
               run.push_back(PAD_CHAR);
            end
            default: ;
         endcase
         run.push_back(TERM_CHAR);
         grp_phase  = PHASE_0;
         carry_bits = 4'h0;
      end
      foreach (run[i]) begin
         cb.ch   = run[i];
         cb.last = (i == run.size() - 1);
         expected_chars.push_back(cb);
      end
   endtask

   task automatic queue_beat(input logic func, input logic [7:0] b);
      in_beat_type nb;
      nb.func = func;
      nb.data = b;
      pending_beats.push_back(nb);
   endtask

   // Input side: a beat is taken at a rising edge with push high and full low;
   // the expectation is formed right there, well ahead of its first character.
   always @(posedge clock) begin : beat_acceptor
      if (!reset && push && !full) begin
         beats_taken++;
         encode_beat(req_func, req_data_byte);
      end
   end

   // Beat driver, acts on the falling edge. The push level for the next cycle
   // is settled in a local first so push sees one assignment per step; a
   // back-to-back beat keeps push high and just swaps the payload.
   always @(negedge clock) begin : beat_driver
      logic        nxt_push;
      in_beat_type nb;
      nxt_push = push;
      if (!reset) begin
         if (push && beats_taken == beats_sent) begin
            nxt_push  = 1'b0;
            push_hold = draw_gap(req_calm);
         end
         if (!nxt_push && pending_beats.size() != 0) begin
            if (push_hold > 0) begin
               push_hold--;
            end else begin
               nb = pending_beats.pop_front();
               req_func      <= nb.func;
               req_data_byte <= nb.data;
               beats_sent++;
               nxt_push = 1'b1;
            end
         end
      end
      push <= nxt_push;
   end

   // Result side: a character beat is taken at a rising edge with pop high and
   // empty low, and checked against the oldest expectation.
   always @(posedge clock) begin : char_checker
      char_beat_type exp_c;
      if (!reset && pop && !empty) begin
         chars_taken++;
         if (expected_chars.size() == 0) begin
            $error("out_char: expected nothing, actual 0x%02h", rsp_out_char);
            mismatches++;
         end else begin
            exp_c = expected_chars.pop_front();
            if (rsp_out_char !== exp_c.ch) begin
               $error("out_char: expected 0x%02h, actual 0x%02h", exp_c.ch, rsp_out_char);
               mismatches++;
            end
            if (rsp_last_in_run !== exp_c.last) begin
               $error("last_in_run: expected %0b, actual %0b", exp_c.last, rsp_last_in_run);
               mismatches++;
            end
         end
      end
   end

   // Pop driver: after each taken character it may back off for a drawn
   // number of cycles; pop may sit high while the encoder has nothing.
   always @(negedge clock) begin : pop_driver
      logic nxt_pop;
      nxt_pop = pop;
      if (!reset) begin
         if (chars_taken != chars_seen) begin
            chars_seen = chars_taken;
            pop_hold   = draw_gap(rsp_calm);
            if (pop_hold > 0) nxt_pop = 1'b0;
         end
         if (!nxt_pop) begin
            if (pop_hold > 0) pop_hold--;
            else nxt_pop = 1'b1;
         end
      end
      pop <= nxt_pop;
   end

   // Stimulus, reset and end of run.
   initial begin : stimulus
      int added;
      int msg_len;
      logic [7:0] b;

      // Directed part.
      queue_beat(FUNC_END, 8'hFF);      // flush straight out of reset, byte ignored
      queue_beat(FUNC_DATA, 8'h00);     // one full group, extremes
      queue_beat(FUNC_DATA, 8'hFF);
      queue_beat(FUNC_DATA, 8'h00);
      queue_beat(FUNC_END, 8'h00);      // flush on a group boundary
      queue_beat(FUNC_DATA, 8'hFF);     // one byte then flush: two pads
      queue_beat(FUNC_END, 8'hA5);
      queue_beat(FUNC_DATA, 8'h0F);     // two bytes then flush: one pad
      queue_beat(FUNC_DATA, 8'hFF);
      queue_beat(FUNC_END, 8'h5A);
      queue_beat(FUNC_DATA, 8'hAA);     // alternating bit patterns across phases
      queue_beat(FUNC_DATA, 8'h55);
      queue_beat(FUNC_DATA, 8'h3C);
      queue_beat(FUNC_DATA, 8'hC3);
      queue_beat(FUNC_END, 8'h00);
      queue_beat(FUNC_DATA, 8'h80);
      queue_beat(FUNC_DATA, 8'h01);
      queue_beat(FUNC_DATA, 8'h7E);
      queue_beat(FUNC_END, 8'hFF);

      // Random messages: mostly short bodies of random bytes closed by a flush,
      // a few empty messages, extreme bytes sprinkled in.
      added = 0;
      while (added < RANDOM_BEATS) begin
         msg_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
         repeat (msg_len) begin
            case ($urandom_range(0, 9))
               0:       b = 8'h00;
               1:       b = 8'hFF;
               default: b = 8'($urandom);
            endcase
            queue_beat(FUNC_DATA, b);
         end
         queue_beat(FUNC_END, 8'($urandom));
         added += msg_len + 1;
      end

      // Synchronous reset, held from time zero and released on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: every beat sent, every character back, then a short quiet tail
      // so stray characters would still be caught.
      while (pending_beats.size() != 0 || push || expected_chars.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
